// File: sv/sirs_pkg.sv
// shared constants and types for the signed integer to radix symbol converter
package sirs_pkg;

  localparam int NUMBER_W     = 32;
  localparam int SYMBOL_W     = 8;
  localparam int COUNT_W      = 5;
  localparam int WORD_W       = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int SYMBOL_SLOTS = 16;

  localparam logic [SYMBOL_W-1:0] MINUS_SIGN      = 8'h2D;
  localparam logic [SYMBOL_W-1:0] PLUS_SIGN       = 8'h2B;
  localparam logic [SYMBOL_W-1:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [SYMBOL_W-1:0] DELETE_CODE     = 8'h7F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT = 2'd0,
    REG_LOW   = 2'd1,
    REG_HIGH  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

// File: sv/sirs_cell.sv
// one digit cell: clear, radix doubling step with carry to the next cell, or shift toward the top
module sirs_cell #(
  parameter int DIGIT_W = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sirs_pkg::cell_ctl_t           ctl,
  input  logic [sirs_pkg::COUNT_W-1:0]  radix,
  input  logic                          vin,
  input  logic                          cin,
  input  logic [DIGIT_W-1:0]            digit_lo,
  output logic                          vout,
  output logic                          cout,
  output logic [DIGIT_W-1:0]            digit
);
  import sirs_pkg::*;

  localparam int SUM_W = (DIGIT_W + 1 > COUNT_W) ? DIGIT_W + 1 : COUNT_W;

  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic               v_r, v_nxt;
  logic               c_r, c_nxt;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   radix_e;
  logic               wrap;

  always_comb begin
    sum     = SUM_W'({digit_r, 1'b0}) + SUM_W'(cin);
    radix_e = SUM_W'(radix);
    wrap    = (sum >= radix_e);
  end

  always_comb begin
    digit_nxt = digit_r;
    v_nxt     = 1'b0;
    c_nxt     = 1'b0;
    if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.shift) begin
      digit_nxt = digit_lo;
    end else if (vin) begin
      v_nxt     = 1'b1;
      c_nxt     = wrap;
      digit_nxt = wrap ? DIGIT_W'(sum - radix_e) : DIGIT_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      c_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
      c_r <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign vout  = v_r;
  assign cout  = c_r;
  assign digit = digit_r;

endmodule

// File: sv/signed_int_to_radix_symbols.sv
// top level: signed integer to text in a configured radix, one symbol per beat
// sequence: the cell row converts the magnitude, then leading zero digits are dropped (one digit
// is always kept), then the minus sign if negative and the digits go out, most significant first;
// a new number is taken only when idle, after the last beat of the previous text has been issued
// or, with a bad alphabet, at once without any output; output stalls hold the text
// reset: synchronous active low, clears configuration and control; digit cells clear on accept
module signed_int_to_radix_symbols #(
  parameter int MAX_RADIX  = 16,
  parameter int MAX_DIGITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sirs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sirs_pkg::WORD_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sirs_pkg::NUMBER_W-1:0] in_number,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sirs_pkg::SYMBOL_W-1:0]        out_symbol,
  output logic                                 out_last
);
  import sirs_pkg::*;

  localparam int DIGIT_W  = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int CONV_LEN = NUMBER_W + MAX_DIGITS - 1;
  localparam int TIMER_W  = $clog2(CONV_LEN);
  localparam int CNT_W    = $clog2(MAX_DIGITS + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_STRIP = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_W-1:0]     count_r;
  logic [WORD_W-1:0]      low_r;
  logic [WORD_W-1:0]      high_r;
  logic                   ok_r, ok_nxt;
  logic                   neg_r, neg_nxt;
  logic [NUMBER_W-1:0]    mag_r, mag_nxt;
  logic [TIMER_W-1:0]     timer_r, timer_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SYMBOL_W-1:0]    out_symbol_r, out_symbol_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [SYMBOL_W-1:0]    sym_a [SYMBOL_SLOTS];
  logic [NUMBER_W-1:0]    num_u;
  logic                   accept;
  logic                   slot_free;
  logic                   feed_v;
  logic                   top_zero;
  logic [DIGIT_W-1:0]     dig_top;
  cell_ctl_t              ctl;

  logic [DIGIT_W-1:0]     dig   [MAX_DIGITS];
  logic                   v_c   [MAX_DIGITS];
  logic                   c_c   [MAX_DIGITS];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign num_u     = in_number;
  assign dig_top   = dig[MAX_DIGITS-1];
  assign top_zero  = (dig_top == '0);
  assign feed_v    = (state_r == ST_CONV) && (timer_r < TIMER_W'(NUMBER_W));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      low_r   <= '0;
      high_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        REG_LOW:   low_r   <= cfg_data;
        REG_HIGH:  high_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sym_a[i]     = low_r[8*i +: 8];
      sym_a[i + 8] = high_r[8*i +: 8];
    end
  end

  // alphabet check
  always_comb begin
    ok_nxt = (count_r >= COUNT_W'(2)) && (count_r <= COUNT_W'(SYMBOL_SLOTS)) &&
             (int'(count_r) <= MAX_RADIX);
    for (int i = 0; i < SYMBOL_SLOTS; i++) begin
      if (COUNT_W'(i) < count_r) begin
        if (sym_a[i] == PLUS_SIGN || sym_a[i] == MINUS_SIGN ||
            sym_a[i] < FIRST_PRINTABLE || sym_a[i] >= DELETE_CODE) begin
          ok_nxt = 1'b0;
        end
        for (int j = i + 1; j < SYMBOL_SLOTS; j++) begin
          if (COUNT_W'(j) < count_r && sym_a[j] == sym_a[i]) ok_nxt = 1'b0;
        end
      end
    end
  end

  // cell row, cell 0 least significant
  always_comb begin
    ctl.clear = accept;
    ctl.shift = ((state_r == ST_STRIP) && top_zero && (cnt_r > CNT_W'(1))) ||
                ((state_r == ST_EMIT) && slot_free);
  end

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    if (k == 0) begin : g_first
      sirs_cell #(.DIGIT_W(DIGIT_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .radix    (count_r),
        .vin      (feed_v),
        .cin      (mag_r[NUMBER_W-1]),
        .digit_lo ('0),
        .vout     (v_c[k]),
        .cout     (c_c[k]),
        .digit    (dig[k])
      );
    end else begin : g_next
      sirs_cell #(.DIGIT_W(DIGIT_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .radix    (count_r),
        .vin      (v_c[k-1]),
        .cin      (c_c[k-1]),
        .digit_lo (dig[k-1]),
        .vout     (v_c[k]),
        .cout     (c_c[k]),
        .digit    (dig[k])
      );
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    timer_nxt      = timer_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_nxt   = num_u[NUMBER_W-1];
          mag_nxt   = num_u[NUMBER_W-1] ? (NUMBER_W'(0) - num_u) : num_u;
          timer_nxt = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (timer_r == '0 && !ok_r) begin
          state_nxt = ST_IDLE;
        end else begin
          mag_nxt   = {mag_r[NUMBER_W-2:0], 1'b0};
          timer_nxt = TIMER_W'(timer_r + 1'b1);
          if (timer_r == TIMER_W'(CONV_LEN - 1)) begin
            cnt_nxt   = CNT_W'(MAX_DIGITS);
            state_nxt = ST_STRIP;
          end
        end
      end
      ST_STRIP: begin
        if (top_zero && cnt_r > CNT_W'(1)) begin
          cnt_nxt = CNT_W'(cnt_r - 1'b1);
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = MINUS_SIGN;
          out_last_nxt   = 1'b0;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = sym_a[4'(dig_top)];
          out_last_nxt   = (cnt_r == CNT_W'(1));
          cnt_nxt        = CNT_W'(cnt_r - 1'b1);
          if (cnt_r == CNT_W'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
      timer_r     <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
      timer_r     <= timer_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

// File: sv/sirs_chk.sv
// port checker for the radix symbol converter, bound to the top level
module sirs_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [sirs_pkg::SYMBOL_W-1:0]        out_symbol,
  input logic                                 out_last
);
  import sirs_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(out_last))
    else $error("stalled output beat changed");

  // one number at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while converting");

  // no new number while a text is still open
  a_no_accept_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a text");

  // the minus sign never ends a text
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol == MINUS_SIGN |-> !out_last)
    else $error("minus sign marked last");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind signed_int_to_radix_symbols sirs_chk u_sirs_chk (.*);

// File: bench/testbench.sv
// testbench for the signed integer to radix symbol converter: directed table, then random alphabets
module testbench;
  import sirs_pkg::*;

  localparam int          RANDOM_ITEMS = 500;
  localparam int          QUIET_CYCLES = 200;
  localparam longint      LIMIT_CYCLES = 1_000_000;
  localparam int          TEXT_CHARS   = 11;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam logic [WORD_W-1:0] DIGITS_LO  = 64'h3736_3534_3332_3130;
  localparam logic [WORD_W-1:0] DECIMAL_HI = 64'hFFFF_FFFF_FFFF_3938;
  localparam logic [WORD_W-1:0] HEX_HI     = 64'h4645_4443_4241_3938;
  localparam logic [WORD_W-1:0] EDGE_LO    = 64'h0000_0000_0000_7E20;
  localparam logic [WORD_W-1:0] PLUS_LO    = 64'h0000_0000_3231_2B30;
  localparam logic [WORD_W-1:0] MINUS_LO   = 64'h0000_0000_3231_2D30;
  localparam logic [WORD_W-1:0] LOW_CTL_LO = 64'h0000_0000_3231_1F30;
  localparam logic [WORD_W-1:0] DEL_LO     = 64'h0000_0000_3231_7F30;
  localparam logic [WORD_W-1:0] TWIN_LO    = 64'h0000_0000_3130_3230;
  localparam logic [WORD_W-1:0] QUAD_LO    = 64'h0000_0000_3332_3130;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_NUM,
    ROW_NUM_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [CFG_IDX_W-1:0]        index;
    logic [WORD_W-1:0]           data;
    logic signed [NUMBER_W-1:0]  number;
    logic [3:0]                  text_len;
    logic [TEXT_CHARS*8-1:0]     text;
  } dir_row_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
  } char_beat_t;

  localparam int DIR_ROWS = 44;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd12345,       4'd0,  88'h0},
    '{ROW_CFG,       REG_COUNT, 64'd10,      32'sd0,           4'd0,  88'h0},
    '{ROW_CFG,       REG_LOW,   DIGITS_LO,   32'sd0,           4'd0,  88'h0},
    '{ROW_CFG,       REG_HIGH,  DECIMAL_HI,  32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd0,           4'd1,  "0"},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       -32'sd1,          4'd2,  "-1"},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sh7FFF_FFFF,   4'd10, "2147483647"},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sh8000_0000,   4'd11, "-2147483648"},
    '{ROW_NUM,       REG_COUNT, 64'h0,       32'sd1000,        4'd0,  88'h0},
    '{ROW_CFG,       REG_COUNT, 64'd16,      32'sd0,           4'd0,  88'h0},
    '{ROW_CFG,       REG_HIGH,  HEX_HI,      32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sh7FFF_FFFF,   4'd8,  "7FFFFFFF"},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sh8000_0000,   4'd9,  "-80000000"},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       -32'sd255,        4'd3,  "-FF"},
    '{ROW_CFG,       REG_NONE,  64'd2,       32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd255,         4'd2,  "FF"},
    '{ROW_CFG,       REG_COUNT, 64'd2,       32'sd0,           4'd0,  88'h0},
    '{ROW_CFG,       REG_LOW,   EDGE_LO,     32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd0,           4'd1,  " "},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       -32'sd1,          4'd2,  "-~"},
    '{ROW_NUM,       REG_COUNT, 64'h0,       32'sh8000_0000,   4'd0,  88'h0},
    '{ROW_NUM,       REG_COUNT, 64'h0,       32'sh7FFF_FFFF,   4'd0,  88'h0},
    '{ROW_NUM,       REG_COUNT, 64'h0,       32'sh5555_5555,   4'd0,  88'h0},
    '{ROW_CFG,       REG_COUNT, 64'd1,       32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd7,           4'd0,  88'h0},
    '{ROW_CFG,       REG_COUNT, 64'd17,      32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd7,           4'd0,  88'h0},
    '{ROW_CFG,       REG_COUNT, 64'd31,      32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd7,           4'd0,  88'h0},
    '{ROW_CFG,       REG_COUNT, 64'd4,       32'sd0,           4'd0,  88'h0},
    '{ROW_CFG,       REG_LOW,   PLUS_LO,     32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd9,           4'd0,  88'h0},
    '{ROW_CFG,       REG_LOW,   MINUS_LO,    32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd9,           4'd0,  88'h0},
    '{ROW_CFG,       REG_LOW,   LOW_CTL_LO,  32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd9,           4'd0,  88'h0},
    '{ROW_CFG,       REG_LOW,   DEL_LO,      32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd9,           4'd0,  88'h0},
    '{ROW_CFG,       REG_LOW,   TWIN_LO,     32'sd0,           4'd0,  88'h0},
    '{ROW_NUM_TYPED, REG_COUNT, 64'h0,       32'sd9,           4'd0,  88'h0},
    '{ROW_CFG,       REG_LOW,   QUAD_LO,     32'sd0,           4'd0,  88'h0},
    '{ROW_NUM,       REG_COUNT, 64'h0,       32'sd27,          4'd0,  88'h0},
    '{ROW_CFG,       REG_COUNT, 64'hFFFF_FFFF_FFFF_FFE3, 32'sd0, 4'd0, 88'h0},
    '{ROW_NUM,       REG_COUNT, 64'h0,       32'sd5,           4'd0,  88'h0}
  };

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        cfg_valid  = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index  = '0;
  logic [WORD_W-1:0]           cfg_data   = '0;
  logic                        in_valid   = 1'b0;
  logic                        in_ready;
  logic signed [NUMBER_W-1:0]  in_number  = '0;
  logic                        out_valid;
  logic                        out_ready  = 1'b0;
  logic [SYMBOL_W-1:0]         out_symbol;
  logic                        out_last;

  logic [COUNT_W-1:0] radix_reg = '0;
  logic [WORD_W-1:0]  low_reg   = '0;
  logic [WORD_W-1:0]  high_reg  = '0;

  char_beat_t awaited_beats [$];
  int         mismatches    = 0;
  int         counted_items = 0;
  bit         calm          = 1'b0;

  signed_int_to_radix_symbols DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_number  (in_number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 14);
  endfunction

  function automatic logic [SYMBOL_W-1:0] glyph(input int unsigned i);
    logic [WORD_W-1:0] word;
    word = (i < 8) ? low_reg : high_reg;
    return word[(i % 8) * 8 +: 8];
  endfunction

  function automatic bit alphabet_ok();
    int unsigned i, j;
    logic [SYMBOL_W-1:0] c;
    if (radix_reg < 2 || radix_reg > SYMBOL_SLOTS) return 1'b0;
    for (i = 0; i < radix_reg; i++) begin
      c = glyph(i);
      if (c == PLUS_SIGN || c == MINUS_SIGN || c < FIRST_PRINTABLE || c >= DELETE_CODE)
        return 1'b0;
      for (j = i + 1; j < radix_reg; j++)
        if (glyph(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // text of one number in the current alphabet, sign first, most significant digit first
  function automatic void render_number(input logic signed [NUMBER_W-1:0] num);
    logic [NUMBER_W-1:0] mag;
    logic [SYMBOL_W-1:0] digits [$];
    int i;
    if (!alphabet_ok()) return;
    if (num == 0) begin
      awaited_beats.push_back('{glyph(0), 1'b1});
      return;
    end
    mag = num;
    if (num < 0) begin
      mag = ~mag + 1'b1;
      awaited_beats.push_back('{MINUS_SIGN, 1'b0});
    end
    while (mag != 0) begin
      digits.push_front(glyph(mag % radix_reg));
      mag = mag / radix_reg;
    end
    for (i = 0; i < digits.size(); i++)
      awaited_beats.push_back('{digits[i], i == digits.size() - 1});
  endfunction

  function automatic logic signed [NUMBER_W-1:0] pick_number();
    logic [NUMBER_W-1:0] v;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: v = $urandom;
      4, 5: v = $urandom_range(0, 300);
      6: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = '1;
          2: v = 32'd1;
          3: v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      7: begin
        v = 32'd1;
        repeat ($urandom_range(0, 31)) v = v * radix_reg;
        v = v + $urandom_range(0, 2) - 1;
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if (kind >= 4 && kind != 6 && $urandom_range(0, 1)) v = ~v + 1'b1;
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    in_valid <= 1'b0;
    while (take_break()) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COUNT: radix_reg = value[COUNT_W-1:0];
      REG_LOW:   low_reg   = value;
      REG_HIGH:  high_reg  = value;
      default: ;
    endcase
  endtask

  task automatic send_number(input logic signed [NUMBER_W-1:0] num, input bit typed,
                             input logic [3:0] len, input logic [TEXT_CHARS*8-1:0] text);
    int i;
    cfg_valid <= 1'b0;
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= num;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      for (i = len; i > 0; i--)
        awaited_beats.push_back('{text[(i - 1) * 8 +: 8], i == 1});
    end else begin
      render_number(num);
    end
  endtask

  task automatic drain(input bit with_pause);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (awaited_beats.size() != 0);
    if (with_pause) repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic load_random_alphabet(input bit broken);
    logic [SYMBOL_W-1:0] sym [SYMBOL_SLOTS];
    logic [WORD_W-1:0]   count_word;
    int unsigned         count, j, k;
    bit                  clash;
    count = $urandom_range(2, SYMBOL_SLOTS);
    for (j = 0; j < SYMBOL_SLOTS; j++) sym[j] = $urandom_range(0, 255);
    for (j = 0; j < count; j++) begin
      do begin
        sym[j] = $urandom_range(FIRST_PRINTABLE, DELETE_CODE - 1);
        clash = (sym[j] == PLUS_SIGN) || (sym[j] == MINUS_SIGN);
        for (k = 0; k < j; k++)
          if (sym[k] == sym[j]) clash = 1'b1;
      end while (clash);
    end
    if (broken) begin
      j = $urandom_range(0, count - 1);
      k = (j + $urandom_range(1, count - 1)) % count;
      case ($urandom_range(0, 5))
        0: count = $urandom_range(0, 1);
        1: count = $urandom_range(SYMBOL_SLOTS + 1, 31);
        2: sym[j] = PLUS_SIGN;
        3: sym[j] = MINUS_SIGN;
        4: sym[j] = $urandom_range(0, 1) ? $urandom_range(0, FIRST_PRINTABLE - 1)
                                         : $urandom_range(DELETE_CODE, 255);
        default: sym[j] = sym[k];
      endcase
    end
    count_word = {$urandom, $urandom};
    count_word[COUNT_W-1:0] = count[COUNT_W-1:0];
    write_reg(REG_COUNT, count_word);
    write_reg(REG_LOW, {sym[7], sym[6], sym[5], sym[4], sym[3], sym[2], sym[1], sym[0]});
    write_reg(REG_HIGH, {sym[15], sym[14], sym[13], sym[12],
                         sym[11], sym[10], sym[9], sym[8]});
    if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, {$urandom, $urandom});
  endtask

  always @(posedge clk) out_ready <= !take_break();

  always @(posedge clk) begin : watch_output
    char_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: symbol %h last %b", out_symbol, out_last);
      end else begin
        want = awaited_beats.pop_front();
        if (out_symbol !== want.symbol || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: expected symbol %h last %b, got symbol %h last %b",
                     want.symbol, want.last, out_symbol, out_last);
        end
      end
    end
  end

  initial begin
    int unsigned r, left, phase;
    bit          prev_cfg, broken;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    prev_cfg = 1'b1;
    for (r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        if (!prev_cfg) drain(1'b1);
        write_reg(DIRECTED[r].index, DIRECTED[r].data);
      end else begin
        send_number(DIRECTED[r].number, DIRECTED[r].kind == ROW_NUM_TYPED,
                    DIRECTED[r].text_len, DIRECTED[r].text);
      end
      prev_cfg = (DIRECTED[r].kind == ROW_CFG);
    end
    phase = 0;
    while (counted_items < RANDOM_ITEMS) begin
      drain(1'b1);
      // no idling on either side for a few phases
      calm = (phase >= 2 && phase <= 4);
      broken = (phase % 7 == 5);
      load_random_alphabet(broken);
      left = broken ? 3 : $urandom_range(20, 45);
      repeat (left) begin
        if ($urandom_range(0, 59) == 0) drain(1'b0);
        send_number(pick_number(), 1'b0, 4'd0, '0);
        if (!broken) counted_items++;
      end
      phase++;
    end
    drain(1'b1);
    if (mismatches == 0 && awaited_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("tb: failure");
    $finish;
  end

endmodule
